// ===== rtl/vertex_dedup_indexer_top_defines.svh =====
// Assertion macros shared by the vertex dedup indexer RTL.
// Needs a clk and rst in scope where used.
`ifndef VERTEX_DEDUP_INDEXER_TOP_DEFINES_SVH
`define VERTEX_DEDUP_INDEXER_TOP_DEFINES_SVH

// same-cycle implication
`define VDI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define VDI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/vdi_pkg.sv =====
// Package for the vertex dedup indexer: word types, FSM states, control structs.
// No dependencies.
`timescale 1ns / 1ps
package vdi_pkg;
  localparam int unsigned TableDepth = 1024;
  localparam int unsigned KeyWords = 8;
  localparam int unsigned WordW = 32;
  localparam int unsigned KeyW = KeyWords * WordW;
  localparam int unsigned IndexW = 10;

  typedef logic [KeyW-1:0] key_t;

  typedef struct packed {
    logic              first_of_mesh;
    logic [WordW-1:0]  pos_x;
    logic [WordW-1:0]  pos_y;
    logic [WordW-1:0]  pos_z;
    logic [WordW-1:0]  tex_u;
    logic [WordW-1:0]  tex_v;
    logic [WordW-1:0]  norm_x;
    logic [WordW-1:0]  norm_y;
    logic [WordW-1:0]  norm_z;
  } in_word_t;

  typedef struct packed {
    logic [IndexW-1:0] vertex_index;
    logic              is_new;
    logic              overflow;
    logic [WordW-1:0]  uniq_pos_x;
    logic [WordW-1:0]  uniq_pos_y;
    logic [WordW-1:0]  uniq_pos_z;
    logic [WordW-1:0]  uniq_tex_u;
    logic [WordW-1:0]  uniq_tex_v;
    logic [WordW-1:0]  uniq_norm_x;
    logic [WordW-1:0]  uniq_norm_y;
    logic [WordW-1:0]  uniq_norm_z;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic load_res;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic more;
    logic rd_pend;
    logic hit;
    logic out_free;
  } status_t;
endpackage

// ===== rtl/vdi_if.sv =====
// Valid/ready channel interfaces for input and result words.
// Depends on vdi_pkg.
`timescale 1ns / 1ps
interface vdi_in_if;
  logic              valid;
  logic              ready;
  vdi_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vdi_out_if;
  logic               valid;
  logic               ready;
  vdi_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/vertex_dedup_indexer_top.sv =====
// Vertex dedup indexer: input word is one vertex (eight 32-bit float bit
// patterns and a first_of_mesh flag); the result word is its index in the
// compacted buffer plus new/overflow flags and the vertex copy when new.
// Both channels are valid/ready; a word moves when valid and ready are high.
// The table is scanned linearly, one stored row per cycle from a
// single-port synchronous memory. With N vertices stored in the current
// mesh, the scan ends on a match or once all N rows are compared (at once
// when the table is empty); the result goes to the result registers, then
// to the output register, and only then is the next word accepted.
// One item is worked at a time.
// The result sits in an output register: the next vertex is accepted while
// it waits, and a stalled receiver holds the block only once the following
// result is also ready.
// first_of_mesh empties the table before the lookup. A new vertex with the
// table full gives overflow and index 0 and is not stored.
// Reset (rst, synchronous) empties the table and the output register; no
// memory clearing pass is needed.
// Depends on vdi_pkg, vdi_if, vdi_ctrl, vdi_datapath.
`timescale 1ns / 1ps
module vertex_dedup_indexer_top #(
  parameter int unsigned TABLE_DEPTH = vdi_pkg::TableDepth
) (
  input logic      clk,
  input logic      rst,
  vdi_in_if.sink   in_ch,
  vdi_out_if.source out_ch
);
  vdi_pkg::cmd_t    cmd;
  vdi_pkg::status_t status;

  vdi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  vdi_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_ch.data),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_data  (out_ch.data),
    .cmd       (cmd),
    .status    (status)
  );
endmodule

// ===== rtl/vdi_ctrl.sv =====
// Controller FSM: accept, table scan, result hand-off.
// Depends on vdi_pkg.
`timescale 1ns / 1ps
module vdi_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  vdi_pkg::status_t status,
  output vdi_pkg::cmd_t    cmd
);
  vdi_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vdi_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      vdi_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = vdi_pkg::ST_SCAN;
        end
      end
      vdi_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.hit || (!status.more && !status.rd_pend)) begin
          cmd.load_res = 1'b1;
          state_next = vdi_pkg::ST_DONE;
        end
      end
      vdi_pkg::ST_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next = vdi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = vdi_pkg::ST_IDLE;
      end
    endcase
  end
endmodule

// ===== rtl/vdi_datapath.sv =====
// Datapath: key register, vertex table memory, scan compare, result registers.
// Depends on vdi_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "vertex_dedup_indexer_top_defines.svh"
module vdi_datapath #(
  parameter int unsigned TABLE_DEPTH = vdi_pkg::TableDepth
) (
  input  logic               clk,
  input  logic               rst,
  input  vdi_pkg::in_word_t  in_data,
  input  logic               out_ready,
  output logic               out_valid,
  output vdi_pkg::out_word_t out_data,
  input  vdi_pkg::cmd_t      cmd,
  output vdi_pkg::status_t   status
);
  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  vdi_pkg::key_t key;
  vdi_pkg::key_t rd_data;
  vdi_pkg::key_t mem [TABLE_DEPTH];

  logic [CntW-1:0] count;
  logic [CntW-1:0] idx;
  logic [IdxW-1:0] rd_idx;
  logic            rd_pend;
  logic            full;
  logic            hit;
  logic            insert;
  logic            issue;

  logic [IdxW-1:0] res_idx;
  logic            res_new;
  logic            res_ovf;
  logic [31:0]     res_idx_wide;

  assign full   = (count == CntW'(TABLE_DEPTH));
  assign hit    = rd_pend && (rd_data == key);
  assign issue  = cmd.scan && (idx < count);
  assign insert = cmd.load_res && !hit && !full;

  assign status.more     = (idx < count);
  assign status.rd_pend  = rd_pend;
  assign status.hit      = hit;
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= mem[idx[IdxW-1:0]];
    end
    if (insert) begin
      mem[count[IdxW-1:0]] <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      idx     <= '0;
      rd_pend <= 1'b0;
    end else begin
      if (cmd.accept) begin
        idx     <= '0;
        rd_pend <= 1'b0;
        if (in_data.first_of_mesh) begin
          count <= '0;
        end
      end else if (cmd.scan) begin
        rd_pend <= issue;
        if (issue) begin
          idx <= idx + CntW'(1);
        end
      end
      if (insert) begin
        count <= count + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_idx <= idx[IdxW-1:0];
    end
    if (cmd.accept) begin
      key <= {in_data.pos_x, in_data.pos_y, in_data.pos_z, in_data.tex_u,
              in_data.tex_v, in_data.norm_x, in_data.norm_y, in_data.norm_z};
    end
    if (cmd.load_res) begin
      res_new <= insert;
      res_ovf <= !hit && full;
      if (hit) begin
        res_idx <= rd_idx;
      end else if (!full) begin
        res_idx <= count[IdxW-1:0];
      end else begin
        res_idx <= '0;
      end
    end
  end

  assign res_idx_wide = 32'(res_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.vertex_index <= res_idx_wide[vdi_pkg::IndexW-1:0];
      out_data.is_new       <= res_new;
      out_data.overflow     <= res_ovf;
      {out_data.uniq_pos_x, out_data.uniq_pos_y, out_data.uniq_pos_z,
       out_data.uniq_tex_u, out_data.uniq_tex_v, out_data.uniq_norm_x,
       out_data.uniq_norm_y, out_data.uniq_norm_z} <= res_new ? key : '0;
    end
  end

  `VDI_ASSERT_NOW(a_count_bound, 1'b1, count <= CntW'(TABLE_DEPTH), "entry count past depth")
  `VDI_ASSERT_NOW(a_no_insert_full, insert, !full && !hit, "insert into full table or on hit")
  `VDI_ASSERT_NEXT(a_count_step, insert && !cmd.accept, count == $past(count) + CntW'(1),
                   "count did not advance on insert")
endmodule
